/* sv/pngunf_pkg.sv */
// Shared types, register indexes and constants of the PNG scanline unfilter core.
package pngunf_pkg;

  localparam int MAX_LINE_BYTES  = 8192;
  localparam int LINE_BYTES_W    = 14;
  localparam int PIXEL_BYTES_W   = 4;
  localparam int MAX_PIXEL_BYTES = 8;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 14;
  localparam int OUT_QUEUE_DEPTH = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_LINE_BYTES  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_BYTES = 2'd1;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       pass_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       line_end;
    logic       error;
  } out_item_t;

endpackage

/* sv/pngunf_recon.sv */
// Per-byte filter reconstruction: None, Sub, Up, Average and Paeth predictors.
module pngunf_recon (
  input  pngunf_pkg::filt_t filt,
  input  logic [7:0]        cur,
  input  logic [7:0]        a,
  input  logic [7:0]        b,
  input  logic [7:0]        c,
  output logic [7:0]        r
);

  logic signed [9:0] d_pa;
  logic signed [9:0] d_pb;
  logic signed [9:0] d_pc;
  logic [8:0]        pa;
  logic [8:0]        pb;
  logic [8:0]        pc;
  logic [8:0]        sum_ab;
  logic [7:0]        paeth;
  logic [7:0]        pred;

  always_comb begin
    d_pa = $signed({2'b00, b}) - $signed({2'b00, c});
    d_pb = $signed({2'b00, a}) - $signed({2'b00, c});
    d_pc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
    pa = d_pa[9] ? 9'(-d_pa) : d_pa[8:0];
    pb = d_pb[9] ? 9'(-d_pb) : d_pb[8:0];
    pc = d_pc[9] ? 9'(-d_pc) : d_pc[8:0];
    if (pa <= pb && pa <= pc) begin
      paeth = a;
    end else if (pb <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
    sum_ab = {1'b0, a} + {1'b0, b};
    case (filt)
      pngunf_pkg::FILT_SUB:   pred = a;
      pngunf_pkg::FILT_UP:    pred = b;
      pngunf_pkg::FILT_AVG:   pred = sum_ab[8:1];
      pngunf_pkg::FILT_PAETH: pred = paeth;
      default:                pred = 8'd0;
    endcase
    r = cur + pred;
  end

endmodule

/* sv/pngunf_out_fifo.sv */
// Small result queue that decouples the reconstruction stage from the output handshake.
module pngunf_out_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  pngunf_pkg::out_item_t push_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pngunf_pkg::out_item_t out_data,
  output logic [1:0]            count
);

  localparam logic [1:0] LAST_SLOT = 2'(pngunf_pkg::OUT_QUEUE_DEPTH - 1);

  pngunf_pkg::out_item_t slots [pngunf_pkg::OUT_QUEUE_DEPTH];
  logic [1:0]            wr_ptr;
  logic [1:0]            rd_ptr;
  logic                  pop;

  assign out_valid = (count != 2'd0);
  assign out_data  = slots[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? 2'd0 : wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? 2'd0 : rd_ptr + 2'd1;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

/* sv/png_scanline_unfilter_core.sv */
// Top level of the PNG scanline unfilter core.
// The core takes one stream byte per clock while in_ready is high and returns one reconstructed
// byte for every filtered data byte; a valid filter-type byte produces nothing. The
// previous-row memory is read at the edge that accepts a data byte. The next cycle computes
// the predictor, writes the rebuilt byte back and pushes the result into a three-entry output
// queue. Input is held off only while the queued results and the byte being rebuilt fill
// three queue entries, so with the output always ready the core takes one request per clock.
// The previous-row memory has one read and one write port, and a data byte written back is
// forwarded to the next read when the addresses match. The previous row is cleared on a pass
// start through a fill count, so there is no clearing sweep and no dead time after reset. An
// unknown filter type returns an error result and makes every later request return one too
// until reset. Configuration must be written through cfg_we/cfg_index/cfg_data only while the
// core is idle; the user is bound by this, as the core itself does not enforce it.
module png_scanline_unfilter_core #(
  parameter int MAX_LINE_BYTES = pngunf_pkg::MAX_LINE_BYTES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  pngunf_pkg::in_item_t                 in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output pngunf_pkg::out_item_t                out_data,
  input  logic                                 cfg_we,
  input  logic [pngunf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pngunf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int PW   = $clog2(MAX_LINE_BYTES);
  localparam int LW   = $clog2(MAX_LINE_BYTES + 1);
  localparam int LENW = (LW > pngunf_pkg::LINE_BYTES_W) ? LW : pngunf_pkg::LINE_BYTES_W;

  typedef struct packed {
    logic [7:0]        v;
    logic [PW-1:0]     pos;
    pngunf_pkg::filt_t filt;
    logic              first;
    logic              last;
    logic              err;
    logic              prior_ok;
  } s1_t;

  logic [pngunf_pkg::LINE_BYTES_W-1:0]  line_bytes;
  logic [pngunf_pkg::PIXEL_BYTES_W-1:0] pixel_bytes;

  logic [LENW-1:0]  lb_ext;
  logic [LENW-1:0]  eff_len;
  logic [pngunf_pkg::PIXEL_BYTES_W-1:0] eff_bpp;
  logic [2:0]       bpp_idx;

  logic [PW-1:0]     byte_position;
  logic              in_header;
  logic              failed;
  pngunf_pkg::filt_t line_filter;
  logic [LW-1:0]     fill;

  logic [LENW-1:0] pos_full;
  logic [LENW-1:0] pos_c;
  logic [LENW-1:0] pos_next;
  logic [PW-1:0]   rd_pos;
  logic            is_last;
  logic            bad_type;
  logic            accept;

  logic [7:0] prior_mem [MAX_LINE_BYTES];
  logic [7:0] mem_q;
  logic       fwd;
  logic [7:0] fwd_data;

  logic        s1_v;
  s1_t         s1;
  logic [63:0] left_hist;
  logic [63:0] upleft_hist;
  logic [63:0] lh;
  logic [63:0] uh;
  logic [7:0]  a;
  logic [7:0]  b;
  logic [7:0]  c;
  logic [7:0]  r;

  pngunf_pkg::out_item_t push_data;
  logic [1:0]            out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_bytes  <= pngunf_pkg::LINE_BYTES_W'(1);
      pixel_bytes <= pngunf_pkg::PIXEL_BYTES_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        pngunf_pkg::REG_LINE_BYTES:  line_bytes  <= cfg_data;
        pngunf_pkg::REG_PIXEL_BYTES: pixel_bytes <= cfg_data[pngunf_pkg::PIXEL_BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lb_ext = LENW'(line_bytes);
    if (lb_ext == '0) begin
      eff_len = LENW'(1);
    end else if (lb_ext > LENW'(MAX_LINE_BYTES)) begin
      eff_len = LENW'(MAX_LINE_BYTES);
    end else begin
      eff_len = lb_ext;
    end
    if (pixel_bytes == '0) begin
      eff_bpp = pngunf_pkg::PIXEL_BYTES_W'(1);
    end else if (pixel_bytes > pngunf_pkg::PIXEL_BYTES_W'(pngunf_pkg::MAX_PIXEL_BYTES)) begin
      eff_bpp = pngunf_pkg::PIXEL_BYTES_W'(pngunf_pkg::MAX_PIXEL_BYTES);
    end else begin
      eff_bpp = pixel_bytes;
    end
    bpp_idx = 3'(eff_bpp - pngunf_pkg::PIXEL_BYTES_W'(1));

    pos_full = LENW'(byte_position);
    pos_c    = (pos_full >= eff_len) ? eff_len - LENW'(1) : pos_full;
    pos_next = pos_c + LENW'(1);
    rd_pos   = pos_c[PW-1:0];
    is_last  = (pos_next >= eff_len);
    bad_type = (in_data.in_byte > {5'd0, pngunf_pkg::FILT_PAETH});
  end

  assign in_ready = (({1'b0, out_count} + {2'b00, s1_v}) <= 3'd2);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      in_header     <= 1'b1;
      failed        <= 1'b0;
      line_filter   <= pngunf_pkg::FILT_NONE;
      fill          <= '0;
      s1_v          <= 1'b0;
    end else begin
      s1_v <= accept && (failed || !in_header || bad_type);
      if (accept && !failed) begin
        if (in_header) begin
          if (bad_type) begin
            failed <= 1'b1;
          end else begin
            if (in_data.pass_start) begin
              fill <= '0;
            end
            line_filter   <= pngunf_pkg::filt_t'(in_data.in_byte[2:0]);
            byte_position <= '0;
            in_header     <= 1'b0;
          end
        end else begin
          if (pos_next > LENW'(fill)) begin
            fill <= LW'(pos_next);
          end
          if (is_last) begin
            in_header     <= 1'b1;
            byte_position <= '0;
          end else begin
            byte_position <= pos_next[PW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.v        <= in_data.in_byte;
      s1.pos      <= rd_pos;
      s1.filt     <= line_filter;
      s1.first    <= (byte_position == '0);
      s1.last     <= is_last;
      s1.err      <= failed || in_header;
      s1.prior_ok <= (pos_c < LENW'(fill));
      mem_q       <= prior_mem[rd_pos];
      fwd         <= s1_v && !s1.err && (s1.pos == rd_pos);
      fwd_data    <= r;
    end
    if (s1_v && !s1.err) begin
      prior_mem[s1.pos] <= r;
    end
  end

  always_comb begin
    lh = s1.first ? 64'd0 : left_hist;
    uh = s1.first ? 64'd0 : upleft_hist;
    a  = lh[{bpp_idx, 3'b000} +: 8];
    c  = uh[{bpp_idx, 3'b000} +: 8];
    b  = s1.prior_ok ? (fwd ? fwd_data : mem_q) : 8'd0;
  end

  pngunf_recon u_recon (
    .filt (s1.filt),
    .cur  (s1.v),
    .a    (a),
    .b    (b),
    .c    (c),
    .r    (r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      left_hist   <= 64'd0;
      upleft_hist <= 64'd0;
    end else if (s1_v && !s1.err) begin
      left_hist   <= {lh[55:0], r};
      upleft_hist <= {uh[55:0], b};
    end
  end

  always_comb begin
    if (s1.err) begin
      push_data.out_byte = 8'd0;
      push_data.line_end = 1'b0;
      push_data.error    = 1'b1;
    end else begin
      push_data.out_byte = r;
      push_data.line_end = s1.last;
      push_data.error    = 1'b0;
    end
  end

  pngunf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_v),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .count     (out_count)
  );

  // The queue is never full while a result is still being reconstructed.
  assert property (@(posedge clk) disable iff (rst)
    (out_count == 2'(pngunf_pkg::OUT_QUEUE_DEPTH)) |-> !s1_v)
    else $error("result queue overflow");

  // A valid filter-type byte never produces a result.
  assert property (@(posedge clk) disable iff (rst)
    (accept && in_header && !failed && !bad_type) |=> !s1_v)
    else $error("filter-type byte produced a result");

  // The error state holds until reset.
  assert property (@(posedge clk) disable iff (rst) failed |=> failed)
    else $error("error state cleared without reset");

  // The fill count stays within the previous-row memory.
  assert property (@(posedge clk) disable iff (rst) fill <= LW'(MAX_LINE_BYTES))
    else $error("fill count beyond memory depth");

endmodule
